@@ hw/rtl/rstab_pkg.sv @@
// Shared types and constants for the reservation station table.
`timescale 1ns / 1ps

package rstab_pkg;

  // Default table depth and fixed field widths
  localparam int RSTAB_ENTRIES = 16;
  localparam int NUM_W         = 32;
  localparam int TAG_W         = 8;
  localparam int CFG_W         = 5;
  localparam int OUT_IDX_W     = 4;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  // Request operation codes
  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_WAKEUP   = 2'd2,
    MODE_SCHEDULE = 2'd3
  } mode_t;

  // One stored entry payload (valid and scheduled bits live in flops)
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             used1;
    logic [TAG_W-1:0] tag1;
    logic             ready1;
    logic             used2;
    logic [TAG_W-1:0] tag2;
    logic             ready2;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } rstab_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } rstab_sts_t;

endpackage

@@ hw/rtl/reservation_station_table.sv @@
// Reservation station table: n = active entry count, saturated to ENTRIES.
// Each accepted request passes through the scan, drain and finish states before its result is registered.
// The table takes one request at a time; the entry scan reads one RAM word a cycle.
// A finished result waits in an output register; the next request is taken meanwhile.
// Reset (synchronous, active high) clears all valid and scheduled bits and
// sets active_entries to 16; entry payloads stay undefined until written.
`timescale 1ns / 1ps

module reservation_station_table #(
  parameter int ENTRIES = rstab_pkg::RSTAB_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rstab_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      mode,
  input  logic [rstab_pkg::NUM_W-1:0]     seq_num,
  input  logic                            src1_used,
  input  logic [rstab_pkg::TAG_W-1:0]     src1_ptag,
  input  logic                            src1_rdy,
  input  logic                            src2_used,
  input  logic [rstab_pkg::TAG_W-1:0]     src2_ptag,
  input  logic                            src2_rdy,
  input  logic [rstab_pkg::TAG_W-1:0]     broadcast_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            has_space,
  output logic                            done_res,
  output logic [rstab_pkg::OUT_IDX_W-1:0] entry_index
);

  import rstab_pkg::*;

  rstab_cmd_t cmd;
  rstab_sts_t sts;

  // Sequence each request
  rstab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store entries, scan and commit
  rstab_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mode          (mode),
    .seq_num       (seq_num),
    .src1_used     (src1_used),
    .src1_ptag     (src1_ptag),
    .src1_rdy      (src1_rdy),
    .src2_used     (src2_used),
    .src2_ptag     (src2_ptag),
    .src2_rdy      (src2_rdy),
    .broadcast_tag (broadcast_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .has_space     (has_space),
    .done_res      (done_res),
    .entry_index   (entry_index)
  );

endmodule

@@ hw/rtl/rstab_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rstab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/rstab_ctrl.sv @@
// Sequencing state machine for the reservation station table.
`timescale 1ns / 1ps

module rstab_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rstab_pkg::rstab_sts_t sts,
  output rstab_pkg::rstab_cmd_t cmd
);

  import rstab_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

@@ hw/rtl/rstab_dp.sv @@
// Datapath: entry storage, scan pipeline, commit and result register.
`timescale 1ns / 1ps

module rstab_dp #(
  parameter int ENTRIES = rstab_pkg::RSTAB_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rstab_pkg::rstab_cmd_t           cmd,
  output rstab_pkg::rstab_sts_t           sts,
  input  logic                            cfg_wr_en,
  input  logic [rstab_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [1:0]                      mode,
  input  logic [rstab_pkg::NUM_W-1:0]     seq_num,
  input  logic                            src1_used,
  input  logic [rstab_pkg::TAG_W-1:0]     src1_ptag,
  input  logic                            src1_rdy,
  input  logic                            src2_used,
  input  logic [rstab_pkg::TAG_W-1:0]     src2_ptag,
  input  logic                            src2_rdy,
  input  logic [rstab_pkg::TAG_W-1:0]     broadcast_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            has_space,
  output logic                            done_res,
  output logic [rstab_pkg::OUT_IDX_W-1:0] entry_index
);

  import rstab_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  // Configuration and per-entry flags
  logic [CFG_W-1:0] active_entries;
  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] entry_scheduled;
  logic [CW-1:0] live;

  // Latched request
  mode_t            req_mode;
  entry_t           req_entry;
  logic [TAG_W-1:0] req_btag;

  // Scan state
  logic [CW-1:0] cnt;
  logic          s1_vld;
  logic [IW-1:0] s1_idx;
  logic          s1_valid;
  logic          found_free;
  logic          second_free;
  logic [IW-1:0] free_idx;
  logic          found_match;
  logic [IW-1:0] match_idx;

  // RAM ports
  logic          ram_wr_en;
  logic [IW-1:0] ram_wr_addr;
  entry_t        ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_raw;
  entry_t        rd_entry;
  entry_t        wake_entry;
  logic          wake_wr;
  logic          commit_ins;

  // Result values
  logic          res_space;
  logic          res_done;
  logic [IW-1:0] res_pick;

  // Saturate the active count to the built depth
  always_comb begin
    if (CMPW'(active_entries) > CMPW'(ENTRIES)) begin
      live = CW'(ENTRIES);
    end else begin
      live = CW'(active_entries);
    end
  end

  assign sts.scan_done = (cnt == live);
  assign sts.out_free  = !out_valid || !out_stall;

  assign rd_entry = entry_t'(ram_rd_raw);

  // Wakeup update of the entry under compare
  always_comb begin
    wake_entry = rd_entry;
    if (rd_entry.used1 && (rd_entry.tag1 == req_btag)) begin
      wake_entry.ready1 = 1'b1;
    end
    if (rd_entry.used2 && (rd_entry.tag2 == req_btag)) begin
      wake_entry.ready2 = 1'b1;
    end
  end

  assign wake_wr    = s1_vld && s1_valid && (req_mode == MODE_WAKEUP);
  assign commit_ins = cmd.finish && (req_mode == MODE_INSERT) && found_free;

  // Select the write: wakeup write-back during scan, insert at commit
  always_comb begin
    ram_wr_en   = wake_wr || commit_ins;
    ram_wr_addr = s1_idx;
    ram_wr_data = wake_entry;
    if (commit_ins) begin
      ram_wr_addr = free_idx;
      ram_wr_data = req_entry;
    end
  end

  rstab_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.issue),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (ram_rd_raw)
  );

  // Form the result from the scan outcome
  always_comb begin
    res_space = found_free;
    res_done  = 1'b0;
    res_pick  = '0;
    case (req_mode)
      MODE_INSERT: begin
        res_space = second_free;
        res_done  = found_free;
        res_pick  = found_free ? free_idx : '0;
      end
      MODE_REMOVE: begin
        res_space = found_free || found_match;
        res_done  = found_match;
        res_pick  = found_match ? match_idx : '0;
      end
      MODE_WAKEUP: begin
        res_done = 1'b1;
      end
      MODE_SCHEDULE: begin
        res_done = found_match;
        res_pick = found_match ? match_idx : '0;
      end
      default: begin
        res_done = 1'b0;
      end
    endcase
  end

  // Latch request payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_mode         <= mode_t'(mode);
      req_entry.num    <= seq_num;
      req_entry.used1  <= src1_used;
      req_entry.tag1   <= src1_ptag;
      req_entry.ready1 <= src1_rdy;
      req_entry.used2  <= src2_used;
      req_entry.tag2   <= src2_ptag;
      req_entry.ready2 <= src2_rdy;
      req_btag         <= broadcast_tag;
    end
  end

  // Scan pipeline: capture index and valid flag beside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      s1_vld <= 1'b0;
    end else begin
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.issue) begin
        cnt <= cnt + CW'(1);
      end
      s1_vld <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_idx   <= cnt[IW-1:0];
      s1_valid <= entry_valid[cnt[IW-1:0]];
    end
  end

  // Track first and second free entry and first match
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      found_free  <= 1'b0;
      second_free <= 1'b0;
      found_match <= 1'b0;
    end else if (s1_vld) begin
      if (!s1_valid) begin
        if (!found_free) begin
          found_free <= 1'b1;
        end else begin
          second_free <= 1'b1;
        end
      end
      if (s1_valid && (rd_entry.num == req_entry.num) && !found_match) begin
        found_match <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      if (!s1_valid && !found_free) begin
        free_idx <= s1_idx;
      end
      if (s1_valid && (rd_entry.num == req_entry.num) && !found_match) begin
        match_idx <= s1_idx;
      end
    end
  end

  // Configuration, entry flags and commit
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries  <= ACTIVE_RESET;
      entry_valid     <= '0;
      entry_scheduled <= '0;
    end else begin
      if (cfg_wr_en) begin
        active_entries <= cfg_wr_data;
      end
      if (cmd.finish) begin
        case (req_mode)
          MODE_INSERT: begin
            if (found_free) begin
              entry_valid[free_idx]     <= 1'b1;
              entry_scheduled[free_idx] <= 1'b0;
            end
          end
          MODE_REMOVE: begin
            if (found_match) begin
              entry_valid[match_idx] <= 1'b0;
            end
          end
          MODE_SCHEDULE: begin
            if (found_match) begin
              entry_scheduled[match_idx] <= 1'b1;
            end
          end
          default: begin
            entry_valid <= entry_valid;
          end
        endcase
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      has_space   <= res_space;
      done_res    <= res_done;
      entry_index <= OUT_IDX_W'(res_pick);
    end
  end

endmodule
